>>> design/mrl_pkg.sv
// ----------------------------------------------------------------------------
// mrl_pkg: shared definitions for the message rate limiter
// Item kinds, reject reason codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mrl_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned REASON_W = 3;
    localparam int unsigned WCNT_W   = 8;
    localparam int unsigned TCNT_W   = 16;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [WCNT_W-1:0] WCNT_MAX = 8'hFF;
    localparam logic [TCNT_W-1:0] TCNT_MAX = 16'hFFFF;

    localparam logic [REASON_W-1:0] REASON_NONE     = 3'd0;
    localparam logic [REASON_W-1:0] REASON_CHANNEL  = 3'd1;
    localparam logic [REASON_W-1:0] REASON_EMPTY    = 3'd2;
    localparam logic [REASON_W-1:0] REASON_BURST    = 3'd3;
    localparam logic [REASON_W-1:0] REASON_COOLDOWN = 3'd4;

    localparam logic [1:0] CHANNEL_INVALID = 2'd3;
    localparam logic       MODE_CLEAR      = 1'b1;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_BURST_WINDOW     = 2'd0;
    localparam cfg_index_t CFG_BURST_LIMIT      = 2'd1;
    localparam cfg_index_t CFG_MIN_INTERVAL     = 2'd2;
    localparam cfg_index_t CFG_VIOLATION_WINDOW = 2'd3;

    localparam logic [TIME_W-1:0] BURST_WINDOW_RESET     = 32'd10000;
    localparam logic [WCNT_W-1:0] BURST_LIMIT_RESET      = 8'd5;
    localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET     = 32'd500;
    localparam logic [TIME_W-1:0] VIOLATION_WINDOW_RESET = 32'd60000;

    // What the front end decided about a request.
    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_CHANNEL = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_RATE    = 2'd3
    } mrl_kind_t;

    typedef struct packed {
        mrl_kind_t         kind;
        logic [TIME_W-1:0] time_ms;
    } mrl_item_t;

endpackage

>>> design/mrl_if.sv
// ----------------------------------------------------------------------------
// mrl_if: request and response channels of the message rate limiter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mrl_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] time_ms;
    logic [1:0]  channel;
    logic        message_empty;

    modport source (output valid, mode, time_ms, channel, message_empty, input ready);
    modport sink   (input valid, mode, time_ms, channel, message_empty, output ready);
endinterface

interface mrl_rsp_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [2:0]  reject_reason;
    logic [7:0]  window_violations;
    logic [15:0] total_violations;

    modport source (output valid, accepted, reject_reason, window_violations,
                    total_violations, input ready);
    modport sink   (input valid, accepted, reject_reason, window_violations,
                    total_violations, output ready);
endinterface

>>> design/message_rate_limiter.sv
// ----------------------------------------------------------------------------
// message_rate_limiter: chat message rate limiter
// Burst window, minimum interval and violation counters per request beat.
// ----------------------------------------------------------------------------
// Each request beat on req carries a mode, a millisecond timestamp, a channel
// code and an empty-message flag. Every request beat yields exactly one
// response beat on rsp: accepted, a reject reason and the windowed and total
// violation counts. A clear request answers with all fields zero.
// The user writes the four limiter registers through cfg_we, cfg_index and
// cfg_data only while no request is in flight; the block does no check.
// Throughput is one request per cycle while rsp.ready is high. The core
// updates the limiter state once per beat, so requests may follow back to back.
// A request is written into the queue and then registered into the core's
// output stage, whose register drives rsp.valid and the response fields.
// When the receiver stalls, the response holds and the queue keeps
// taking requests until QUEUE_DEPTH are waiting, then req.ready drops.
// Reset empties the queue and output register, loads the register defaults
// and clears all limiter state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module message_rate_limiter #(
    parameter int unsigned QUEUE_DEPTH = mrl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  mrl_pkg::cfg_index_t       cfg_index,
    input  logic [mrl_pkg::CFG_W-1:0] cfg_data,
    mrl_req_if.sink                   req,
    mrl_rsp_if.source                 rsp
);
    import mrl_pkg::*;

    logic      push_valid;
    logic      push_ready;
    mrl_item_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    mrl_item_t pop_data;

    mrl_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    mrl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mrl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

>>> design/mrl_front.sv
// ----------------------------------------------------------------------------
// mrl_front: request classifier
// Sorts each request into clear, bad channel, empty or rate check and
// pushes it into the queue.
// ----------------------------------------------------------------------------
module mrl_front (
    mrl_req_if.sink            req,
    output logic               push_valid,
    output mrl_pkg::mrl_item_t push_data,
    input  logic               push_ready
);
    import mrl_pkg::*;

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    always_comb
    begin
        push_data.time_ms = req.time_ms;
        if (req.mode == MODE_CLEAR)
        begin
            push_data.kind = KIND_CLEAR;
        end
        else if (req.channel == CHANNEL_INVALID)
        begin
            push_data.kind = KIND_CHANNEL;
        end
        else if (req.message_empty)
        begin
            push_data.kind = KIND_EMPTY;
        end
        else
        begin
            push_data.kind = KIND_RATE;
        end
    end

endmodule

>>> design/mrl_queue.sv
// ----------------------------------------------------------------------------
// mrl_queue: short queue between the classifier and the limiter core
// Register-based FIFO with a fill counter.
// ----------------------------------------------------------------------------
module mrl_queue #(
    parameter int unsigned DEPTH = mrl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mrl_pkg::mrl_item_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mrl_pkg::mrl_item_t pop_data
);
    import mrl_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mrl_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/mrl_back.sv
// ----------------------------------------------------------------------------
// mrl_back: limiter core
// Holds the configuration and limiter state, applies the burst, cooldown and
// violation rules, one item a cycle unless rsp stalls, and registers the result.
// ----------------------------------------------------------------------------
module mrl_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  mrl_pkg::cfg_index_t       cfg_index,
    input  logic [mrl_pkg::CFG_W-1:0] cfg_data,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  mrl_pkg::mrl_item_t        pop_data,
    mrl_rsp_if.source                 rsp
);
    import mrl_pkg::*;

    logic [TIME_W-1:0] burst_window_reg;
    logic [WCNT_W-1:0] burst_limit_reg;
    logic [TIME_W-1:0] min_interval_reg;
    logic [TIME_W-1:0] viol_window_reg;

    logic [TIME_W-1:0] seen_time_reg,   seen_time_next;
    logic              seen_valid_reg,  seen_valid_next;
    logic [TIME_W-1:0] acc_time_reg,    acc_time_next;
    logic              acc_valid_reg,   acc_valid_next;
    logic [TIME_W-1:0] burst_time_reg,  burst_time_next;
    logic              burst_valid_reg, burst_valid_next;
    logic [WCNT_W-1:0] burst_count_reg, burst_count_next;
    logic [TIME_W-1:0] viol_time_reg,   viol_time_next;
    logic              viol_valid_reg,  viol_valid_next;
    logic [WCNT_W-1:0] viol_count_reg,  viol_count_next;
    logic [TCNT_W-1:0] viol_total_reg,  viol_total_next;

    logic                out_valid_reg;
    logic                out_accepted_reg;
    logic [REASON_W-1:0] out_reason_reg;
    logic [WCNT_W-1:0]   out_window_reg;
    logic [TCNT_W-1:0]   out_total_reg;

    logic [REASON_W-1:0] reason;
    logic [TIME_W-1:0]   t;
    logic                do_pop;

    // The output register takes a new item when empty or being drained.
    assign pop_ready = !out_valid_reg || rsp.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign t         = pop_data.time_ms;

    always_comb
    begin
        seen_time_next   = seen_time_reg;
        seen_valid_next  = seen_valid_reg;
        acc_time_next    = acc_time_reg;
        acc_valid_next   = acc_valid_reg;
        burst_time_next  = burst_time_reg;
        burst_valid_next = burst_valid_reg;
        burst_count_next = burst_count_reg;
        viol_time_next   = viol_time_reg;
        viol_valid_next  = viol_valid_reg;
        viol_count_next  = viol_count_reg;
        viol_total_next  = viol_total_reg;
        reason           = REASON_NONE;

        // A clear request, or time running backwards, wipes all state.
        if ((pop_data.kind == KIND_CLEAR) || (seen_valid_reg && (t < seen_time_reg)))
        begin
            seen_time_next   = '0;
            seen_valid_next  = 1'b0;
            acc_time_next    = '0;
            acc_valid_next   = 1'b0;
            burst_time_next  = '0;
            burst_valid_next = 1'b0;
            burst_count_next = '0;
            viol_time_next   = '0;
            viol_valid_next  = 1'b0;
            viol_count_next  = '0;
            viol_total_next  = '0;
        end

        if (pop_data.kind != KIND_CLEAR)
        begin
            seen_time_next  = t;
            seen_valid_next = 1'b1;

            case (pop_data.kind)
                KIND_CHANNEL: reason = REASON_CHANNEL;
                KIND_EMPTY:   reason = REASON_EMPTY;
                default:
                begin
                    // The burst window only rolls once the request gets this far.
                    if (!burst_valid_next || ((t - burst_time_next) >= burst_window_reg))
                    begin
                        burst_time_next  = t;
                        burst_valid_next = 1'b1;
                        burst_count_next = '0;
                    end
                    if (burst_count_next >= burst_limit_reg)
                    begin
                        reason = REASON_BURST;
                    end
                    else if (acc_valid_next && ((t - acc_time_next) < min_interval_reg))
                    begin
                        reason = REASON_COOLDOWN;
                    end
                    else
                    begin
                        acc_time_next    = t;
                        acc_valid_next   = 1'b1;
                        burst_count_next = burst_count_next + WCNT_W'(1);
                    end
                end
            endcase

            if (reason != REASON_NONE)
            begin
                if (!viol_valid_next || ((t - viol_time_next) >= viol_window_reg))
                begin
                    viol_time_next  = t;
                    viol_valid_next = 1'b1;
                    viol_count_next = '0;
                end
                if (viol_count_next != WCNT_MAX)
                begin
                    viol_count_next = viol_count_next + WCNT_W'(1);
                end
                if (viol_total_next != TCNT_MAX)
                begin
                    viol_total_next = viol_total_next + TCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_window_reg <= BURST_WINDOW_RESET;
            burst_limit_reg  <= BURST_LIMIT_RESET;
            min_interval_reg <= MIN_INTERVAL_RESET;
            viol_window_reg  <= VIOLATION_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BURST_WINDOW:     burst_window_reg <= cfg_data;
                CFG_BURST_LIMIT:      burst_limit_reg  <= cfg_data[WCNT_W-1:0];
                CFG_MIN_INTERVAL:     min_interval_reg <= cfg_data;
                CFG_VIOLATION_WINDOW: viol_window_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_time_reg   <= '0;
            seen_valid_reg  <= 1'b0;
            acc_time_reg    <= '0;
            acc_valid_reg   <= 1'b0;
            burst_time_reg  <= '0;
            burst_valid_reg <= 1'b0;
            burst_count_reg <= '0;
            viol_time_reg   <= '0;
            viol_valid_reg  <= 1'b0;
            viol_count_reg  <= '0;
            viol_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                seen_time_reg   <= seen_time_next;
                seen_valid_reg  <= seen_valid_next;
                acc_time_reg    <= acc_time_next;
                acc_valid_reg   <= acc_valid_next;
                burst_time_reg  <= burst_time_next;
                burst_valid_reg <= burst_valid_next;
                burst_count_reg <= burst_count_next;
                viol_time_reg   <= viol_time_next;
                viol_valid_reg  <= viol_valid_next;
                viol_count_reg  <= viol_count_next;
                viol_total_reg  <= viol_total_next;
                out_valid_reg   <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            out_accepted_reg <= (pop_data.kind != KIND_CLEAR) && (reason == REASON_NONE);
            out_reason_reg   <= reason;
            out_window_reg   <= viol_count_next;
            out_total_reg    <= viol_total_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.accepted          = out_accepted_reg;
    assign rsp.reject_reason     = out_reason_reg;
    assign rsp.window_violations = out_window_reg;
    assign rsp.total_violations  = out_total_reg;

endmodule

>>> design/mrl_checker.sv
// ----------------------------------------------------------------------------
// mrl_checker: port-level assertions for the message rate limiter
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module mrl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        accepted,
    input logic [2:0]  reject_reason,
    input logic [7:0]  window_violations,
    input logic [15:0] total_violations
);
    import mrl_pkg::*;

    // A stalled response beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted)
            && $stable(reject_reason) && $stable(window_violations)
            && $stable(total_violations))
        else $error("response beat changed while stalled");

    a_accept_reason: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && accepted |-> reject_reason == REASON_NONE)
        else $error("accepted beat carries a reject reason");

    a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> reject_reason == REASON_NONE || reject_reason == REASON_CHANNEL
            || reject_reason == REASON_EMPTY || reject_reason == REASON_BURST
            || reject_reason == REASON_COOLDOWN)
        else $error("unknown reject reason");

    // The windowed count only grows together with the total.
    a_window_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 16'(window_violations) <= total_violations)
        else $error("window count exceeds total count");

    // A rejected request always counts as a violation.
    a_reject_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && reject_reason != REASON_NONE |-> total_violations != 16'd0
            && window_violations != 8'd0)
        else $error("rejected beat without a violation count");

endmodule

bind message_rate_limiter mrl_checker u_mrl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .accepted          (rsp.accepted),
    .reject_reason     (rsp.reject_reason),
    .window_violations (rsp.window_violations),
    .total_violations  (rsp.total_violations)
);
